/* src/tsr_pkg.sv */
package tsr_pkg;

  localparam int ChanCount = 3;
  localparam int DataW     = 10;
  localparam int CountW    = 8;

  // Stream payload widths, padded up to whole bytes.
  localparam int InDataW  = 64;
  localparam int OutDataW = 40;

  localparam int PwmSteps       = 256;
  localparam int OVERLOAD_TICKS = 250;

  localparam int IntLow   = 50;
  localparam int IntHigh  = 1023;
  localparam int IntReset = 1;

  // The duty is the integrator divided by a constant. The division is a
  // multiply by a rounded-up reciprocal; with a 20-bit shift the quotient is
  // exact for every 10-bit dividend and every divisor up to 1024.
  localparam int DutyDivRaw = 1024 / PwmSteps;
  localparam int DutyDiv    = (DutyDivRaw < 1) ? 1 : DutyDivRaw;
  localparam int RecipShift = 20;
  localparam int RecipW     = 21;
  localparam int DutyRecip  = ((1 << RecipShift) + DutyDiv - 1) / DutyDiv;
  localparam int ProdW      = DataW + RecipW;

  localparam int CfgIndexW = 3;

  localparam logic [DataW-1:0] RefResetCh0   = 10'd671;
  localparam logic [DataW-1:0] RefResetCh1   = 10'd279;
  localparam logic [DataW-1:0] RefResetCh2   = 10'd184;
  localparam logic [DataW-1:0] LimitReset    = 10'd55;

  typedef enum logic [CfgIndexW-1:0] {
    REG_REFERENCE_CH0,
    REG_REFERENCE_CH1,
    REG_REFERENCE_CH2,
    REG_SHUNT_LIMIT_CH0,
    REG_SHUNT_LIMIT_CH1,
    REG_SHUNT_LIMIT_CH2
  } tsr_reg_t;

  // What one channel lane hands to the merging stage for one tick.
  typedef struct packed {
    logic [DataW-1:0] acc;
    logic             trip;
  } tsr_lane_res_t;

endpackage

/* src/tsr_lane.sv */
module tsr_lane
  import tsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             ref_clr,
  input  logic [DataW-1:0] reference,
  input  logic [DataW-1:0] shunt_limit,
  input  logic [DataW-1:0] shunt_high,
  input  logic [DataW-1:0] output_sense,
  output tsr_lane_res_t    res
);

  logic [DataW-1:0]  integ;
  logic [CountW-1:0] count;
  logic              trip;

  logic [DataW-1:0]  integ_next;
  logic [CountW-1:0] count_next;
  logic              trip_next;

  logic [DataW-1:0]  diff;
  logic              over;
  logic              trip_set;
  logic              trip_now;
  logic [DataW-1:0]  eff_ref;
  logic signed [DataW+1:0] err;
  logic signed [DataW+1:0] delta;
  logic signed [DataW+1:0] acc;
  logic [DataW-1:0]  acc_clamped;

  always_comb begin
    diff = (shunt_high >= output_sense) ? (shunt_high - output_sense)
                                        : (output_sense - shunt_high);
    over = diff > shunt_limit;

    trip_set = 1'b0;
    if (over) begin
      if (count < CountW'(OVERLOAD_TICKS)) begin
        count_next = count + 1'b1;
        trip_set   = (count == CountW'(OVERLOAD_TICKS - 1));
      end else begin
        count_next = count;
      end
    end else begin
      count_next = '0;
    end
    trip_now = trip | trip_set;

    eff_ref = trip_now ? '0 : reference;
    err     = $signed({2'b00, eff_ref}) - $signed({2'b00, output_sense});
    delta   = err >>> 2;
    acc     = $signed({2'b00, integ}) + delta;

    if (acc < $signed((DataW+2)'(IntLow))) begin
      acc_clamped = DataW'(IntLow);
    end else if (acc > $signed((DataW+2)'(IntHigh))) begin
      acc_clamped = DataW'(IntHigh);
    end else begin
      acc_clamped = acc[DataW-1:0];
    end

    integ_next = step ? acc_clamped : integ;
    // A reference write clears the trip and wins over a tick in the same cycle.
    if (ref_clr) begin
      trip_next = 1'b0;
    end else if (step) begin
      trip_next = trip_now;
    end else begin
      trip_next = trip;
    end

    res.acc  = acc_clamped;
    res.trip = trip_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= DataW'(IntReset);
      count <= '0;
      trip  <= 1'b0;
    end else begin
      integ <= integ_next;
      if (step) begin
        count <= count_next;
      end
      trip <= trip_next;
    end
  end

  a_integ_in_range: assert property (@(posedge clk) disable iff (rst)
    step |=> (integ >= DataW'(IntLow)))
    else $error("integrator left its clamp range after a tick");

  a_trip_onset: assert property (@(posedge clk) disable iff (rst)
    $rose(trip) |-> (count == CountW'(OVERLOAD_TICKS)))
    else $error("trip latched without the overload count reaching its limit");

  a_ref_clears_trip: assert property (@(posedge clk) disable iff (rst)
    ref_clr |=> !trip)
    else $error("reference write did not clear the trip latch");

endmodule

/* src/tsr_merge.sv */
module tsr_merge
  import tsr_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tsr_lane_res_t [ChanCount-1:0]       lane_res,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [OutDataW-1:0]                 out_data
);

  tsr_lane_res_t [ChanCount-1:0] s1_res;
  logic                          s1_valid;
  logic                          stall;
  logic [ProdW-1:0]              prod [ChanCount];
  logic [OutDataW-1:0]           out_data_next;

  assign stall    = out_valid && !out_ready;
  assign in_ready = !s1_valid || !stall;

  always_comb begin
    out_data_next = '0;
    for (int c = 0; c < ChanCount; c++) begin
      prod[c] = ProdW'(s1_res[c].acc) * ProdW'(DutyRecip);
      out_data_next[c*DataW +: DataW] = prod[c][RecipShift +: DataW];
      out_data_next[ChanCount*DataW + c] = s1_res[c].trip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (!stall) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_res <= lane_res;
    end
    if (!stall && s1_valid) begin
      out_data <= out_data_next;
    end
  end

endmodule

/* src/three_channel_supply_regulator.sv */
// Three-channel supply regulator with overcurrent trip.
//
// Input stream (s_*): one transfer per control tick carries the shunt-high
// and output-sense ADC samples of all three channels. Output stream (m_*):
// one transfer per tick carries the three PWM duty values and trip flags.
// Configuration: a write port (cfg_we, cfg_index, cfg_data) sets the three
// references and three current limits; writing a reference also clears that
// channel's trip latch. Write it only while no tick is in flight.
//
// Lane results pass the merge stage register and then the output register.
// Throughput is one tick per cycle when not stalled: three channel lanes run
// side by side, each doing its overload check and integrator update in the
// cycle of the input transfer, and a merging stage scales the integrators to
// duty values with one reciprocal multiply per lane in the following cycle.
// When the receiver stalls, the output register and the merge stage hold up
// to two ticks; s_tready drops only once both are occupied.
// Reset restores the default references and limits, sets every integrator to
// one, clears overload counts and trips, and empties the pipeline.
module three_channel_supply_regulator
  import tsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 s_tvalid,
  output logic                 s_tready,
  // From bit 0 up: shunt_high_ch0, shunt_high_ch1, shunt_high_ch2,
  // output_sense_ch0, output_sense_ch1, output_sense_ch2, four zero bits.
  input  logic [InDataW-1:0]   s_tdata,

  output logic                 m_tvalid,
  input  logic                 m_tready,
  // From bit 0 up: duty_ch0, duty_ch1, duty_ch2, tripped_ch0, tripped_ch1,
  // tripped_ch2, seven zero bits.
  output logic [OutDataW-1:0]  m_tdata,

  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [DataW-1:0]     cfg_data
);

  // Configuration registers, one per channel.
  logic [DataW-1:0] reference   [ChanCount];
  logic [DataW-1:0] shunt_limit [ChanCount];

  logic [ChanCount-1:0]          ref_clr;
  logic                          step;
  tsr_lane_res_t [ChanCount-1:0] lane_res;

  // A tick is taken into every lane at once on an input transfer.
  assign step = s_tvalid && s_tready;

  assign ref_clr[0] = cfg_we && (cfg_index == REG_REFERENCE_CH0);
  assign ref_clr[1] = cfg_we && (cfg_index == REG_REFERENCE_CH1);
  assign ref_clr[2] = cfg_we && (cfg_index == REG_REFERENCE_CH2);

  // Indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      reference[0]   <= RefResetCh0;
      reference[1]   <= RefResetCh1;
      reference[2]   <= RefResetCh2;
      shunt_limit[0] <= LimitReset;
      shunt_limit[1] <= LimitReset;
      shunt_limit[2] <= LimitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REFERENCE_CH0:   reference[0]   <= cfg_data;
        REG_REFERENCE_CH1:   reference[1]   <= cfg_data;
        REG_REFERENCE_CH2:   reference[2]   <= cfg_data;
        REG_SHUNT_LIMIT_CH0: shunt_limit[0] <= cfg_data;
        REG_SHUNT_LIMIT_CH1: shunt_limit[1] <= cfg_data;
        REG_SHUNT_LIMIT_CH2: shunt_limit[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // One lane per channel holds that channel's integrator, count and trip.
  for (genvar i = 0; i < ChanCount; i++) begin : g_lane
    tsr_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .step         (step),
      .ref_clr      (ref_clr[i]),
      .reference    (reference[i]),
      .shunt_limit  (shunt_limit[i]),
      .shunt_high   (s_tdata[i*DataW +: DataW]),
      .output_sense (s_tdata[(ChanCount+i)*DataW +: DataW]),
      .res          (lane_res[i])
    );
  end

  // The merge stage registers the lane results, scales them to duty values
  // and packs the output transfer.
  tsr_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .lane_res  (lane_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
